// ----- rtl/core/interval_text_to_duration_defines.svh -----
// ----------------------------------------------------------------------------
// Interval text to duration: assertion macros
// Shared property forms for the checks in the RTL. They sample on clk and
// are switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TEXT_TO_DURATION_DEFINES_SVH
`define INTERVAL_TEXT_TO_DURATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval_text_to_duration: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval_text_to_duration: next-cycle check failed");

`endif

// ----- rtl/core/itd_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval text to duration: package
// Widths, character codes, field stages and the snapshot type shared by the
// parser and the result pipeline, and the decimal power table of the pipeline.
// ----------------------------------------------------------------------------
package itd_pkg;

  localparam int ACC_W   = 40;
  localparam int FIELD_W = 32;
  localparam int FCNT_W  = 4;
  localparam int MICRO_W = 20;

  localparam int FRACTION_DIGITS_KEPT_DEF = 7;

  localparam logic [ACC_W-1:0]          ACC_MAX   = '1;
  localparam logic signed [FIELD_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] INT32_MIN = 32'sh8000_0000;

  localparam logic [MICRO_W-1:0] MICRO_ONE = 20'd1000000;
  localparam logic [MICRO_W-1:0] MICRO_TOP = 20'd999999;

  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_MIN   = 60;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int DAYS_PER_MONTH = 30;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_Y     = 8'h79;

  typedef enum logic [2:0] {
    STG_YEAR  = 3'd0,
    STG_MONTH = 3'd1,
    STG_DAY   = 3'd2,
    STG_TIME  = 3'd3,
    STG_MIN   = 3'd4,
    STG_SEC   = 3'd5,
    STG_FRAC  = 3'd6
  } itd_stage_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] year_val;
    logic signed [FIELD_W-1:0] month_val;
    logic signed [FIELD_W-1:0] day_val;
    logic [ACC_W-1:0]          hour_val;
    logic [ACC_W-1:0]          minute_val;
    logic [ACC_W-1:0]          second_val;
    logic [FCNT_W-1:0]         frac_cnt;
    logic                      negative;
    logic                      overflow;
  } itd_snap_t;

  function automatic logic [31:0] ten_pow(input logic [FCNT_W-1:0] n);
    logic [31:0] r;
    unique case (n)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/itd_channels.sv -----
// ----------------------------------------------------------------------------
// Interval text to duration: channel interfaces
// Valid/ready channels for text bytes in and durations out.
// ----------------------------------------------------------------------------
interface itd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface itd_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  total_days;
  logic signed [31:0]  whole_seconds;
  logic [19:0]         micro_seconds;
  logic                range_flag;

  modport source (output valid, output total_days, output whole_seconds,
                  output micro_seconds, output range_flag, input ready);
  modport sink   (input valid, input total_days, input whole_seconds,
                  input micro_seconds, input range_flag, output ready);
endinterface

// ----- rtl/core/itd_parser.sv -----
// ----------------------------------------------------------------------------
// Interval text to duration: byte parser
// Holds the parse state, updates it for each accepted byte and hands a
// snapshot of the finished fields to the result pipeline on the last byte.
// ----------------------------------------------------------------------------
module itd_parser #(
  parameter int FRACTION_DIGITS_KEPT = itd_pkg::FRACTION_DIGITS_KEPT_DEF,
  localparam int SCALE_W = $clog2(10 ** FRACTION_DIGITS_KEPT)
) (
  input  logic               clk,
  input  logic               rst_n,
  itd_in_if.sink             in_if,
  output itd_pkg::itd_snap_t snap,
  output logic [SCALE_W-1:0] snap_frac,
  output logic               snap_valid,
  input  logic               snap_ready
);

  localparam int ACC_W   = itd_pkg::ACC_W;
  localparam int FIELD_W = itd_pkg::FIELD_W;
  localparam int FCNT_W  = itd_pkg::FCNT_W;
  localparam logic [ACC_W-1:0]  NEG_LIMIT = ACC_W'(64'h8000_0000);
  localparam logic [ACC_W-1:0]  POS_LIMIT = ACC_W'(64'h7FFF_FFFF);
  localparam logic [FCNT_W-1:0] FCNT_MAX  = FCNT_W'(FRACTION_DIGITS_KEPT);

  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  itd_pkg::itd_stage_t       stage_r, stage_nxt;
  logic [FCNT_W-1:0]         fcnt_r, fcnt_nxt;
  logic signed [FIELD_W-1:0] year_r, year_nxt;
  logic signed [FIELD_W-1:0] month_r, month_nxt;
  logic signed [FIELD_W-1:0] day_r, day_nxt;
  logic [ACC_W-1:0]          hour_r, hour_nxt;
  logic [ACC_W-1:0]          minute_r, minute_nxt;
  logic [ACC_W-1:0]          second_r, second_nxt;
  logic                      skip_r, skip_nxt;
  logic                      stopped_r, stopped_nxt;
  logic                      ovf_r, ovf_nxt;

  logic                      take;
  logic                      is_digit;
  logic [3:0]                digit;
  logic [ACC_W+3:0]          acc_ext;
  logic signed [FIELD_W-1:0] sfield;
  logic                      sfield_ovf;

  assign take       = in_if.valid && in_if.ready;
  assign in_if.ready = snap_ready;
  assign snap_valid = in_if.valid && in_if.last_byte;

  assign is_digit = (in_if.text_byte >= itd_pkg::CH_ZERO) &&
                    (in_if.text_byte <= itd_pkg::CH_NINE);
  assign digit    = 4'(in_if.text_byte - itd_pkg::CH_ZERO);
  assign acc_ext  = (ACC_W+4)'({acc_r, 3'b000}) + (ACC_W+4)'({acc_r, 1'b0}) +
                    (ACC_W+4)'(digit);

  always_comb begin
    sfield_ovf = 1'b0;
    if (neg_r) begin
      if (acc_r > NEG_LIMIT) begin
        sfield     = itd_pkg::INT32_MIN;
        sfield_ovf = 1'b1;
      end else begin
        sfield = FIELD_W'(~acc_r[FIELD_W-1:0] + 1'b1);
      end
    end else begin
      if (acc_r > POS_LIMIT) begin
        sfield     = itd_pkg::INT32_MAX;
        sfield_ovf = 1'b1;
      end else begin
        sfield = FIELD_W'(acc_r[FIELD_W-1:0]);
      end
    end
  end

  always_comb begin
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    stage_nxt   = stage_r;
    fcnt_nxt    = fcnt_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    skip_nxt    = skip_r;
    stopped_nxt = stopped_r;
    ovf_nxt     = ovf_r;
    if (!stopped_r) begin
      if (in_if.text_byte == itd_pkg::CH_NUL) begin
        stopped_nxt = 1'b1;
      end else if (skip_r) begin
        if (in_if.text_byte == itd_pkg::CH_SPACE) begin
          skip_nxt = 1'b0;
        end
      end else if (is_digit) begin
        if (stage_r == itd_pkg::STG_FRAC) begin
          if (fcnt_r < FCNT_MAX) begin
            acc_nxt  = acc_ext[ACC_W-1:0];
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end else if (acc_ext > (ACC_W+4)'(itd_pkg::ACC_MAX)) begin
          acc_nxt = itd_pkg::ACC_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = acc_ext[ACC_W-1:0];
        end
      end else begin
        unique case (in_if.text_byte)
          itd_pkg::CH_MINUS: neg_nxt = 1'b1;
          itd_pkg::CH_Y: begin
            if (stage_r == itd_pkg::STG_YEAR) begin
              year_nxt  = sfield;
              ovf_nxt   = ovf_r || sfield_ovf;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              stage_nxt = itd_pkg::STG_MONTH;
              skip_nxt  = 1'b1;
            end
          end
          itd_pkg::CH_M: begin
            if (stage_r == itd_pkg::STG_YEAR || stage_r == itd_pkg::STG_MONTH) begin
              month_nxt = sfield;
              ovf_nxt   = ovf_r || sfield_ovf;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              stage_nxt = itd_pkg::STG_DAY;
              skip_nxt  = 1'b1;
            end
          end
          itd_pkg::CH_D: begin
            if (stage_r == itd_pkg::STG_YEAR || stage_r == itd_pkg::STG_MONTH ||
                stage_r == itd_pkg::STG_DAY) begin
              day_nxt   = sfield;
              ovf_nxt   = ovf_r || sfield_ovf;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              stage_nxt = itd_pkg::STG_TIME;
              skip_nxt  = 1'b1;
            end
          end
          itd_pkg::CH_COLON: begin
            if (stage_r == itd_pkg::STG_MIN) begin
              minute_nxt = acc_r;
              acc_nxt    = '0;
              stage_nxt  = itd_pkg::STG_SEC;
            end else if (stage_r != itd_pkg::STG_SEC && stage_r != itd_pkg::STG_FRAC) begin
              hour_nxt  = acc_r;
              acc_nxt   = '0;
              stage_nxt = itd_pkg::STG_MIN;
            end
          end
          itd_pkg::CH_DOT: begin
            if (stage_r == itd_pkg::STG_SEC) begin
              second_nxt = acc_r;
              acc_nxt    = '0;
              stage_nxt  = itd_pkg::STG_FRAC;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    snap.year_val   = year_nxt;
    snap.month_val  = month_nxt;
    snap.day_val    = day_nxt;
    snap.hour_val   = hour_nxt;
    snap.minute_val = (stage_nxt == itd_pkg::STG_MIN) ? acc_nxt : minute_nxt;
    snap.second_val = (stage_nxt == itd_pkg::STG_SEC) ? acc_nxt : second_nxt;
    snap.frac_cnt   = fcnt_nxt;
    snap.negative   = neg_nxt;
    snap.overflow   = ovf_nxt;
    snap_frac       = (stage_nxt == itd_pkg::STG_FRAC) ? acc_nxt[SCALE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_if.last_byte)) begin
      acc_r     <= '0;
      neg_r     <= 1'b0;
      stage_r   <= itd_pkg::STG_YEAR;
      fcnt_r    <= '0;
      year_r    <= '0;
      month_r   <= '0;
      day_r     <= '0;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      skip_r    <= 1'b0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (take) begin
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      stage_r   <= stage_nxt;
      fcnt_r    <= fcnt_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      skip_r    <= skip_nxt;
      stopped_r <= stopped_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

`include "interval_text_to_duration_defines.svh"

  `ITD_ASSERT_SAME(a_frac_count_in_fraction, fcnt_r != '0, stage_r == itd_pkg::STG_FRAC)
  `ITD_ASSERT_SAME(a_frac_count_bound, 1'b1, fcnt_r <= FCNT_MAX)

endmodule

// ----- rtl/core/itd_finish.sv -----
// ----------------------------------------------------------------------------
// Interval text to duration: result pipeline
// Seven registered stages turn a field snapshot into days, whole seconds and
// rounded microseconds, with saturation. Each stage fills when it is empty
// or its content moves on, so results queue up behind a stalled output.
// ----------------------------------------------------------------------------
module itd_finish #(
  parameter int FRACTION_DIGITS_KEPT = itd_pkg::FRACTION_DIGITS_KEPT_DEF,
  localparam int SCALE_W = $clog2(10 ** FRACTION_DIGITS_KEPT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  itd_pkg::itd_snap_t snap,
  input  logic [SCALE_W-1:0] snap_frac,
  input  logic               snap_valid,
  output logic               snap_ready,
  itd_out_if.source          out_if
);

  localparam int NSTG    = 7;
  localparam int ACC_W   = itd_pkg::ACC_W;
  localparam int FIELD_W = itd_pkg::FIELD_W;
  localparam int FCNT_W  = itd_pkg::FCNT_W;
  localparam int MICRO_W = itd_pkg::MICRO_W;
  localparam int HS_W    = ACC_W + 12;
  localparam int MS_W    = ACC_W + 6;
  localparam int W_W     = HS_W + 1;
  localparam int WH_W    = W_W + 2;
  localparam int DAYS_W  = FIELD_W + 11;
  localparam int X_W     = SCALE_W + 1;
  localparam int Q_INT   = 10 ** (FRACTION_DIGITS_KEPT - 6);
  localparam logic [SCALE_W-1:0] SCALE  = SCALE_W'(10 ** FRACTION_DIGITS_KEPT);
  localparam logic [X_W-1:0]     Q      = X_W'(Q_INT);
  localparam logic [X_W-1:0]     HALF_Q = X_W'(Q_INT / 2);
  localparam logic [63:0]        RECIP64 = (64'd1 << X_W) / 64'(Q_INT);
  localparam logic [X_W-1:0]     RECIP  = RECIP64[X_W-1:0];

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // Stage 1: snapshot
  itd_pkg::itd_snap_t s1_r;
  logic [SCALE_W-1:0] frac1_r;
  // Stage 2: products
  logic [HS_W-1:0]          hs2_r;
  logic [MS_W-1:0]          ms2_r;
  logic [ACC_W-1:0]         se2_r;
  logic signed [DAYS_W-1:0] yd2_r, md2_r, dy2_r;
  logic [SCALE_W-1:0]       fu2_r;
  logic                     neg2_r, ovf2_r;
  // Stage 3: sums
  logic [W_W-1:0]           w3_r;
  logic signed [DAYS_W-1:0] days3_r;
  logic [SCALE_W-1:0]       g3_r;
  logic                     borrow3_r, neg3_r, ovf3_r;
  // Stage 4: signed seconds, day saturation, rounding offset
  logic signed [WH_W-1:0]    whole4_r;
  logic signed [FIELD_W-1:0] days4_r;
  logic [X_W-1:0]            x4_r;
  logic                      flag4_r;
  // Stage 5: quotient estimate
  logic [MICRO_W-1:0]        q5_r;
  logic [X_W-1:0]            x5_r;
  logic signed [WH_W-1:0]    whole5_r;
  logic signed [FIELD_W-1:0] days5_r;
  logic                      flag5_r;
  // Stage 6: corrected microseconds
  logic [MICRO_W-1:0]        micro6_r;
  logic signed [WH_W-1:0]    whole6_r;
  logic signed [FIELD_W-1:0] days6_r;
  logic                      flag6_r;
  // Stage 7: output register
  logic signed [FIELD_W-1:0] days7_r;
  logic signed [FIELD_W-1:0] secs7_r;
  logic [MICRO_W-1:0]        micro7_r;
  logic                      flag7_r;

  logic [2*X_W-1:0]          prod5;
  logic [MICRO_W+X_W-1:0]    qq6;
  logic [X_W-1:0]            rem6;
  logic [MICRO_W-1:0]        micro6_nxt;
  logic signed [WH_W-1:0]    whole7_c;
  logic [MICRO_W-1:0]        micro7_c;
  logic signed [FIELD_W-1:0] secs7_nxt;
  logic [MICRO_W-1:0]        micro7_nxt;
  logic                      flag7_nxt;
  logic signed [FIELD_W-1:0] days4_nxt;
  logic                      dflag4;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_if.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign snap_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= snap_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r    <= snap;
      frac1_r <= snap_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hs2_r  <= HS_W'(s1_r.hour_val) * HS_W'(itd_pkg::SECS_PER_HOUR);
      ms2_r  <= MS_W'(s1_r.minute_val) * MS_W'(itd_pkg::SECS_PER_MIN);
      se2_r  <= s1_r.second_val;
      yd2_r  <= DAYS_W'(s1_r.year_val) * DAYS_W'(itd_pkg::DAYS_PER_YEAR);
      md2_r  <= DAYS_W'(s1_r.month_val) * DAYS_W'(itd_pkg::DAYS_PER_MONTH);
      dy2_r  <= DAYS_W'(s1_r.day_val);
      fu2_r  <= SCALE_W'(32'(frac1_r) *
                itd_pkg::ten_pow(FCNT_W'(FRACTION_DIGITS_KEPT) - s1_r.frac_cnt));
      neg2_r <= s1_r.negative;
      ovf2_r <= s1_r.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      w3_r      <= W_W'(hs2_r) + W_W'(ms2_r) + W_W'(se2_r);
      days3_r   <= yd2_r + md2_r + dy2_r;
      g3_r      <= (neg2_r && fu2_r != '0) ? SCALE - fu2_r : fu2_r;
      borrow3_r <= neg2_r && fu2_r != '0;
      neg3_r    <= neg2_r;
      ovf3_r    <= ovf2_r;
    end
  end

  always_comb begin
    dflag4 = 1'b0;
    if (days3_r > DAYS_W'(itd_pkg::INT32_MAX)) begin
      days4_nxt = itd_pkg::INT32_MAX;
      dflag4    = 1'b1;
    end else if (days3_r < DAYS_W'(itd_pkg::INT32_MIN)) begin
      days4_nxt = itd_pkg::INT32_MIN;
      dflag4    = 1'b1;
    end else begin
      days4_nxt = days3_r[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      whole4_r <= neg3_r ? -signed'(WH_W'(w3_r)) - signed'(WH_W'(borrow3_r))
                         : signed'(WH_W'(w3_r));
      days4_r  <= days4_nxt;
      x4_r     <= X_W'(g3_r) + HALF_Q;
      flag4_r  <= ovf3_r || dflag4;
    end
  end

  assign prod5 = (2*X_W)'(x4_r) * (2*X_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      q5_r     <= prod5[X_W +: MICRO_W];
      x5_r     <= x4_r;
      whole5_r <= whole4_r;
      days5_r  <= days4_r;
      flag5_r  <= flag4_r;
    end
  end

  assign qq6        = (MICRO_W+X_W)'(q5_r) * (MICRO_W+X_W)'(Q);
  assign rem6       = x5_r - qq6[X_W-1:0];
  assign micro6_nxt = (rem6 >= Q) ? q5_r + 1'b1 : q5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      micro6_r <= micro6_nxt;
      whole6_r <= whole5_r;
      days6_r  <= days5_r;
      flag6_r  <= flag5_r;
    end
  end

  always_comb begin
    if (micro6_r == itd_pkg::MICRO_ONE) begin
      whole7_c = whole6_r + WH_W'(1);
      micro7_c = '0;
    end else begin
      whole7_c = whole6_r;
      micro7_c = micro6_r;
    end
    flag7_nxt = flag6_r;
    if (whole7_c > WH_W'(itd_pkg::INT32_MAX)) begin
      secs7_nxt  = itd_pkg::INT32_MAX;
      micro7_nxt = itd_pkg::MICRO_TOP;
      flag7_nxt  = 1'b1;
    end else if (whole7_c < WH_W'(itd_pkg::INT32_MIN)) begin
      secs7_nxt  = itd_pkg::INT32_MIN;
      micro7_nxt = '0;
      flag7_nxt  = 1'b1;
    end else begin
      secs7_nxt  = whole7_c[FIELD_W-1:0];
      micro7_nxt = micro7_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      days7_r  <= days6_r;
      secs7_r  <= secs7_nxt;
      micro7_r <= micro7_nxt;
      flag7_r  <= flag7_nxt;
    end
  end

  assign out_if.valid         = vld_r[NSTG-1];
  assign out_if.total_days    = days7_r;
  assign out_if.whole_seconds = secs7_r;
  assign out_if.micro_seconds = micro7_r;
  assign out_if.range_flag    = flag7_r;

`include "interval_text_to_duration_defines.svh"

  `ITD_ASSERT_SAME(a_micro_out_range, vld_r[NSTG-1], micro7_r < itd_pkg::MICRO_ONE)
  `ITD_ASSERT_SAME(a_micro_pre_carry, vld_r[5], micro6_r <= itd_pkg::MICRO_ONE)
  `ITD_ASSERT_SAME(a_blocked_means_full, !rdy[0], &vld_r)

endmodule

// ----- rtl/core/interval_text_to_duration.sv -----
// ----------------------------------------------------------------------------
// Interval text to duration: top level
// Parses interval text one byte per transaction and returns a day count,
// whole seconds and microseconds for each text.
//
//   Channel  Direction  Payload                                       Note
//   in_if    sink       text_byte, last_byte                           one byte each
//   out_if   source     total_days, whole_seconds, micro_seconds,      one per text
//                       range_flag
//
// One byte is taken every cycle while in_if.ready is high. A result reaches the
// output register through the registered stages of the result pipeline after
// the transaction that carries last_byte. Synchronous reset clears the parse
// state and all stage valid bits. Up to seven results can wait behind a stalled
// output; only when all stages hold one does in_if.ready drop.
// ----------------------------------------------------------------------------
module interval_text_to_duration #(
  parameter int FRACTION_DIGITS_KEPT = itd_pkg::FRACTION_DIGITS_KEPT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itd_in_if.sink     in_if,
  itd_out_if.source  out_if
);

  localparam int SCALE_W = $clog2(10 ** FRACTION_DIGITS_KEPT);

  itd_pkg::itd_snap_t snap;
  logic [SCALE_W-1:0] snap_frac;
  logic               snap_valid;
  logic               snap_ready;

  itd_parser #(
    .FRACTION_DIGITS_KEPT(FRACTION_DIGITS_KEPT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .snap      (snap),
    .snap_frac (snap_frac),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready)
  );

  itd_finish #(
    .FRACTION_DIGITS_KEPT(FRACTION_DIGITS_KEPT)
  ) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap      (snap),
    .snap_frac (snap_frac),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .out_if    (out_if)
  );

endmodule

// ----- tb/tb_interval_text_to_duration.sv -----
// ----------------------------------------------------------------------------
// Testbench for interval_text_to_duration
// Interval text goes in one byte per transaction. A directed set of texts
// comes first, then random texts: mostly well-formed ones with random
// content, and some noise. Both channels idle in random bursts. A parser
// model kept in the testbench predicts each duration, and every result
// transaction is checked against it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_interval_text_to_duration;

  localparam int CLK_PERIOD  = 10;
  localparam int FRAC_KEEP   = itd_pkg::FRACTION_DIGITS_KEPT_DEF;
  localparam int RANDOM_SPAN = 1650;
  localparam int CALM_TAIL   = 200;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 30;
  localparam int ACC_W       = itd_pkg::ACC_W;
  localparam int FIELD_W     = itd_pkg::FIELD_W;
  localparam int FCNT_W      = itd_pkg::FCNT_W;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic signed [31:0] days;
    logic signed [31:0] secs;
    logic [19:0]        usec;
    logic               flag;
  } duration_t;

  logic clk = 1'b0;
  logic rst_n;

  itd_in_if  in_ch ();
  itd_out_if out_ch ();

  interval_text_to_duration #(
    .FRACTION_DIGITS_KEPT(FRAC_KEEP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  text_item_t pending_bytes[$];
  duration_t  expected_durations[$];
  logic [7:0] text_buf[$];

  // Parser state.
  logic [ACC_W-1:0]          acc_val;
  logic                      neg_seen;
  itd_pkg::itd_stage_t       stage;
  logic [FCNT_W-1:0]         frac_cnt;
  logic signed [FIELD_W-1:0] yr_val, mo_val, dy_val;
  logic [ACC_W-1:0]          hr_val, mn_val, sc_val;
  logic                      skipping, halted, ovf_seen;

  text_item_t drv_item;
  int         in_gap, out_gap;
  logic       idle_on = 1'b1;
  int         stall_cycles;
  int         n_err;
  logic       timed_out;

  task automatic reset_parser();
    acc_val  = '0;
    neg_seen = 1'b0;
    stage    = itd_pkg::STG_YEAR;
    frac_cnt = '0;
    yr_val   = '0;
    mo_val   = '0;
    dy_val   = '0;
    hr_val   = '0;
    mn_val   = '0;
    sc_val   = '0;
    skipping = 1'b0;
    halted   = 1'b0;
    ovf_seen = 1'b0;
  endtask

  function automatic longint unsigned dec_scale(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  function automatic logic signed [31:0] signed_date();
    logic signed [63:0] mag;
    mag = {24'd0, acc_val};
    if (neg_seen) begin
      if (mag > 64'sd2147483648) begin
        ovf_seen = 1'b1;
        return itd_pkg::INT32_MIN;
      end
      mag = -mag;
      return mag[31:0];
    end
    if (mag > 64'sd2147483647) begin
      ovf_seen = 1'b1;
      return itd_pkg::INT32_MAX;
    end
    return mag[31:0];
  endfunction

  task automatic close_date(output logic signed [FIELD_W-1:0] dst,
                            input itd_pkg::itd_stage_t nxt);
    dst      = signed_date();
    acc_val  = '0;
    neg_seen = 1'b0;
    stage    = nxt;
    skipping = 1'b1;
  endtask

  task automatic parse_byte(input logic [7:0] c);
    logic [63:0] d;
    if (c == itd_pkg::CH_NUL) begin
      halted = 1'b1;
    end else if (skipping) begin
      if (c == itd_pkg::CH_SPACE) skipping = 1'b0;
    end else if (c >= itd_pkg::CH_ZERO && c <= itd_pkg::CH_NINE) begin
      d = 64'(c - itd_pkg::CH_ZERO);
      if (stage == itd_pkg::STG_FRAC) begin
        if (frac_cnt < FRAC_KEEP) begin
          acc_val  = acc_val * 10 + d;
          frac_cnt = frac_cnt + 1'b1;
        end
      end else if (64'(acc_val) > (64'(itd_pkg::ACC_MAX) - d) / 10) begin
        acc_val  = itd_pkg::ACC_MAX;
        ovf_seen = 1'b1;
      end else begin
        acc_val = acc_val * 10 + d;
      end
    end else begin
      case (c)
        itd_pkg::CH_MINUS: neg_seen = 1'b1;
        itd_pkg::CH_Y: if (stage == itd_pkg::STG_YEAR) close_date(yr_val, itd_pkg::STG_MONTH);
        itd_pkg::CH_M: if (stage <= itd_pkg::STG_MONTH) close_date(mo_val, itd_pkg::STG_DAY);
        itd_pkg::CH_D: if (stage <= itd_pkg::STG_DAY) close_date(dy_val, itd_pkg::STG_TIME);
        itd_pkg::CH_COLON: begin
          if (stage <= itd_pkg::STG_TIME) begin
            hr_val  = acc_val;
            acc_val = '0;
            stage   = itd_pkg::STG_MIN;
          end else if (stage == itd_pkg::STG_MIN) begin
            mn_val  = acc_val;
            acc_val = '0;
            stage   = itd_pkg::STG_SEC;
          end
        end
        itd_pkg::CH_DOT: begin
          if (stage == itd_pkg::STG_SEC) begin
            sc_val  = acc_val;
            acc_val = '0;
            stage   = itd_pkg::STG_FRAC;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic finish_duration();
    longint unsigned hr64, mi, s, fu, w, sc, hf, micro;
    longint          whole, dsum;
    logic            flag;
    hr64 = hr_val;
    mi   = mn_val;
    s    = sc_val;
    fu   = 0;
    if (stage == itd_pkg::STG_MIN) mi = acc_val;
    else if (stage == itd_pkg::STG_SEC) s = acc_val;
    else if (stage == itd_pkg::STG_FRAC) fu = acc_val * dec_scale(FRAC_KEEP - frac_cnt);

    w  = hr64 * itd_pkg::SECS_PER_HOUR + mi * itd_pkg::SECS_PER_MIN + s;
    sc = dec_scale(FRAC_KEEP);
    hf = sc / 2;
    if (!neg_seen) begin
      whole = longint'(w);
      micro = (fu * 1000000 + hf) / sc;
    end else if (fu == 0) begin
      whole = -longint'(w);
      micro = 0;
    end else begin
      whole = -longint'(w) - 1;
      micro = ((sc - fu) * 1000000 + hf) / sc;
    end
    if (micro >= itd_pkg::MICRO_ONE) begin
      whole = whole + 1;
      micro = micro - itd_pkg::MICRO_ONE;
    end

    flag = ovf_seen;
    if (whole > longint'(itd_pkg::INT32_MAX)) begin
      whole = longint'(itd_pkg::INT32_MAX);
      micro = itd_pkg::MICRO_TOP;
      flag  = 1'b1;
    end else if (whole < longint'(itd_pkg::INT32_MIN)) begin
      whole = longint'(itd_pkg::INT32_MIN);
      micro = 0;
      flag  = 1'b1;
    end

    dsum = longint'(yr_val) * itd_pkg::DAYS_PER_YEAR
         + longint'(mo_val) * itd_pkg::DAYS_PER_MONTH
         + longint'(dy_val);
    if (dsum > longint'(itd_pkg::INT32_MAX)) begin
      dsum = longint'(itd_pkg::INT32_MAX);
      flag = 1'b1;
    end else if (dsum < longint'(itd_pkg::INT32_MIN)) begin
      dsum = longint'(itd_pkg::INT32_MIN);
      flag = 1'b1;
    end

    expected_durations.push_back(duration_t'{days: 32'(dsum), secs: 32'(whole),
                                             usec: 20'(micro), flag: flag});
    reset_parser();
  endtask

  // Text building.
  task automatic add_str(input string s);
    foreach (s[i]) text_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++)
      text_buf.push_back(itd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_text();
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
    foreach (text_buf[i]) begin
      pending_bytes.push_back(text_item_t'{ch: text_buf[i],
                                           last: (i == text_buf.size() - 1)});
    end
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    add_str(s);
    send_text();
  endtask

  function automatic int num_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 15);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_date(input string word);
    if ($urandom_range(0, 3) == 0) add_str("-");
    add_digits(num_len());
    if ($urandom_range(0, 3) != 0) add_str(" ");
    add_str(word);
    if ($urandom_range(0, 15) != 0) add_str(" ");
  endtask

  task automatic add_noise(input int len);
    string pool;
    int    r;
    pool = "0123456789-ymd:. ";
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      else if (r < 9) text_buf.push_back(8'($urandom_range(0, 255)));
      else text_buf.push_back(itd_pkg::CH_NUL);
    end
  endtask

  task automatic gen_wellformed();
    string yr_words[3];
    string mo_words[3];
    string dy_words[3];
    int    parts;
    yr_words = '{"years", "year", "y"};
    mo_words = '{"mons", "mon", "m"};
    dy_words = '{"days", "day", "d"};
    if ($urandom_range(0, 1)) add_date(yr_words[$urandom_range(0, 2)]);
    if ($urandom_range(0, 1)) add_date(mo_words[$urandom_range(0, 2)]);
    if ($urandom_range(0, 1)) add_date(dy_words[$urandom_range(0, 2)]);
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 2) == 0) add_str("-");
      add_digits(num_len());
      parts = $urandom_range(0, 3);
      if (parts >= 1) begin
        add_str(":");
        add_digits(num_len());
      end
      if (parts >= 2) begin
        add_str(":");
        add_digits(num_len());
      end
      if (parts == 3) begin
        add_str(".");
        add_digits($urandom_range(0, 9));
      end
    end
    if ($urandom_range(0, 7) == 0) add_noise($urandom_range(1, 4));
  endtask

  // Input side: prediction on each accepted byte, then the driver.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (!halted) parse_byte(in_ch.text_byte);
      if (in_ch.last_byte) finish_duration();
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) idle_on <= ~idle_on;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap != 0) begin
        in_gap      <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (idle_on && pending_bytes.size() > CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= $urandom_range(0, 7);
      end else begin
        drv_item         = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= drv_item.ch;
        in_ch.last_byte <= drv_item.last;
      end
    end
  end

  // Output side: check each result transaction, then set ready.
  task automatic check_duration();
    duration_t got, want;
    got = '{days: out_ch.total_days, secs: out_ch.whole_seconds,
            usec: out_ch.micro_seconds, flag: out_ch.range_flag};
    if (expected_durations.size() == 0) begin
      n_err++;
      if (n_err <= 10)
        $display("unexpected result: days %0d secs %0d usec %0d flag %0b",
                 got.days, got.secs, got.usec, got.flag);
    end else begin
      want = expected_durations.pop_front();
      if (got.days !== want.days || got.secs !== want.secs ||
          got.usec !== want.usec || got.flag !== want.flag) begin
        n_err++;
        if (n_err <= 10)
          $display({"mismatch: expected days %0d secs %0d usec %0d flag %0b, ",
                    "got days %0d secs %0d usec %0d flag %0b"},
                   want.days, want.secs, want.usec, want.flag,
                   got.days, got.secs, got.usec, got.flag);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_duration();
      if (out_gap != 0) begin
        out_gap      <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && pending_bytes.size() > CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        out_gap      <= $urandom_range(0, 7);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    int base;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    n_err           = 0;
    stall_cycles    = 0;
    timed_out       = 1'b0;
    reset_parser();

    send_str("1 year 2 mons -3 days 04:05:06.789");
    send_str("-1 d -00:00:00.5");
    send_str("0:0:0.9999996");
    send_str("0:0:1.12345678");
    send_str("99999999999999999 y");
    send_str("-2147483648 d -2147483649 d");
    send_str("2147483647 y 1:2");
    send_str("5 d 3 y 7 m 1:2:3");
    send_str(".5 1:2:3:4.5.6");
    send_str("x1#2 d");
    add_str("3 dx");
    text_buf.push_back(itd_pkg::CH_NUL);
    add_str("5:00");
    send_text();
    add_str("1:00");
    text_buf.push_back(itd_pkg::CH_NUL);
    add_str("99 y");
    send_text();
    send_str("7 d 12");
    send_str("999999:00:00");
    send_str("-999999:00:00.5");
    send_str("-1:-2:3");
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h80);
    add_str("2:3");
    text_buf.push_back(8'h7F);
    send_text();
    send_str("5");
    text_buf.push_back(itd_pkg::CH_NUL);
    send_text();

    base = pending_bytes.size();
    while (pending_bytes.size() < base + RANDOM_SPAN) begin
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 12));
      else gen_wellformed();
      send_text();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while ((pending_bytes.size() != 0 || in_ch.valid || expected_durations.size() != 0) &&
           stall_cycles < STALL_LIMIT)
      @(posedge clk);
    timed_out = (stall_cycles >= STALL_LIMIT);
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && n_err == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
